// ===== rtl/gtf_pkg.sv =====
// Shared types and constants for the glyph text framebuffer.
// Used by gtf_glyph_engine and glyph_text_framebuffer; depends on nothing.
package gtf_pkg;

    localparam int GLYPH_COUNT   = 96;
    localparam int PANEL_COLUMNS = 128;
    localparam int GLYPH_COLUMNS = 12;

    localparam int GLYPH_BYTES = 1 + 2 * GLYPH_COLUMNS;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
    localparam int PAGE_COUNT  = 4;
    localparam int FRAME_DEPTH = PAGE_COUNT * PANEL_COLUMNS;
    localparam int CMD_BYTES   = 3;
    localparam int PAGE_STREAM = CMD_BYTES + PANEL_COLUMNS;
    localparam int FIRST_CODE  = 32;

    localparam int FONT_AW  = $clog2(FONT_DEPTH);
    localparam int FRAME_AW = $clog2(FRAME_DEPTH);
    localparam int GLYPH_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int COL_W    = $clog2(PANEL_COLUMNS + 1);
    localparam int STEP_W   = $clog2(GLYPH_BYTES);
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int OFF_W    = $clog2(PAGE_STREAM);
    localparam int SUM_W    = ((COL_W > 8) ? COL_W : 8) + 1;

    localparam logic [7:0] BYTE_COL_LO    = 8'h00;
    localparam logic [7:0] BYTE_COL_HI    = 8'h10;
    localparam logic [7:0] BYTE_PAGE_BASE = 8'hB0;

    localparam logic [OFF_W-1:0] OFF_COL_LO = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_COL_HI = OFF_W'(1);

    localparam logic [1:0] LINE_UPPER = 2'd1;
    localparam logic [1:0] LINE_LOWER = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [11:0] font_index;
        logic [7:0]  font_byte;
        logic [1:0]  text_line;
        logic [7:0]  symbol;
    } item_t;

    typedef struct packed {
        logic       out_valid;
        logic       out_is_data;
        logic [7:0] out_byte;
        logic       frame_last;
        logic       bad_symbol;
    } result_t;

    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         data;
    } font_wr_t;

    typedef struct packed {
        logic               start;
        logic               lower;
        logic [COL_W-1:0]   column;
        logic [GLYPH_W-1:0] glyph;
    } draw_req_t;

    typedef struct packed {
        logic                we;
        logic [FRAME_AW-1:0] addr;
        logic [7:0]          data;
    } frame_wr_t;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] column;
    } draw_done_t;

endpackage

// ===== rtl/gtf_glyph_engine.sv =====
// Font store and glyph copy sequencer: reads one font byte per cycle and
// emits framebuffer writes for the column pairs. Depends on gtf_pkg.
module gtf_glyph_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gtf_pkg::font_wr_t      font_wr,
    input  gtf_pkg::draw_req_t     draw_req,
    output gtf_pkg::frame_wr_t     frame_wr,
    output gtf_pkg::draw_done_t    draw_done,
    output logic                   busy
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_BASE,
        E_RUN,
        E_DRAIN
    } eng_state_t;

    localparam logic [gtf_pkg::STEP_W-1:0] LAST_STEP = gtf_pkg::STEP_W'(gtf_pkg::GLYPH_BYTES - 1);

    eng_state_t                     state_reg;
    logic                           lower_reg;
    logic [gtf_pkg::COL_W-1:0]      column_reg;
    logic [gtf_pkg::GLYPH_W-1:0]    glyph_reg;
    logic [gtf_pkg::FONT_AW-1:0]    base_reg;
    logic [gtf_pkg::STEP_W-1:0]     step_reg;
    logic                           rd_pend_reg;
    logic [gtf_pkg::STEP_W-1:0]     rd_step_reg;
    logic [7:0]                     width_reg;
    logic [7:0]                     font_rdata_reg;
    logic [7:0]                     font_mem [gtf_pkg::FONT_DEPTH];

    logic [gtf_pkg::FONT_AW-1:0]    rd_addr;
    logic [gtf_pkg::STEP_W-1:0]     pair;
    logic [gtf_pkg::COL_W:0]        col_sum;
    logic [gtf_pkg::PAGE_W-1:0]     page;
    logic [gtf_pkg::SUM_W-1:0]      adv;
    logic [gtf_pkg::COL_W-1:0]      column_next;

    assign rd_addr = base_reg + gtf_pkg::FONT_AW'(step_reg);

    always_ff @(posedge aclk) begin
        if (font_wr.we) begin
            font_mem[font_wr.addr] <= font_wr.data;
        end
        font_rdata_reg <= font_mem[rd_addr];
    end

    always_comb begin
        pair    = rd_step_reg - gtf_pkg::STEP_W'(1);
        col_sum = (gtf_pkg::COL_W + 1)'(column_reg) + (gtf_pkg::COL_W + 1)'(pair >> 1);
        page    = {lower_reg, pair[0]};
        adv     = gtf_pkg::SUM_W'(column_reg) + gtf_pkg::SUM_W'(width_reg);
        if (adv > gtf_pkg::SUM_W'(gtf_pkg::PANEL_COLUMNS)) begin
            column_next = gtf_pkg::COL_W'(gtf_pkg::PANEL_COLUMNS);
        end else begin
            column_next = adv[gtf_pkg::COL_W-1:0];
        end
        frame_wr.we   = rd_pend_reg && (rd_step_reg != '0)
                        && (col_sum < (gtf_pkg::COL_W + 1)'(gtf_pkg::PANEL_COLUMNS));
        frame_wr.addr = gtf_pkg::FRAME_AW'(page) * gtf_pkg::FRAME_AW'(gtf_pkg::PANEL_COLUMNS)
                        + gtf_pkg::FRAME_AW'(col_sum);
        frame_wr.data = font_rdata_reg;
        draw_done.done   = (state_reg == E_DRAIN);
        draw_done.column = column_next;
        busy = (state_reg != E_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            if (rd_pend_reg && (rd_step_reg == '0)) begin
                width_reg <= font_rdata_reg;
            end
            case (state_reg)
                E_IDLE: begin
                    rd_pend_reg <= 1'b0;
                    if (draw_req.start) begin
                        lower_reg  <= draw_req.lower;
                        column_reg <= draw_req.column;
                        glyph_reg  <= draw_req.glyph;
                        state_reg  <= E_BASE;
                    end
                end
                E_BASE: begin
                    base_reg  <= gtf_pkg::FONT_AW'(glyph_reg)
                                 * gtf_pkg::FONT_AW'(gtf_pkg::GLYPH_BYTES);
                    step_reg  <= '0;
                    state_reg <= E_RUN;
                end
                E_RUN: begin
                    rd_pend_reg <= 1'b1;
                    rd_step_reg <= step_reg;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= E_DRAIN;
                    end else begin
                        step_reg <= step_reg + gtf_pkg::STEP_W'(1);
                    end
                end
                E_DRAIN: begin
                    rd_pend_reg <= 1'b0;
                    state_reg   <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/glyph_text_framebuffer.sv =====
// Top level of the glyph text framebuffer: framebuffer store, refresh stream
// and item handshake. Depends on gtf_pkg and gtf_glyph_engine.
//
// Usage: each word on the s_ channel is one item (load font byte, draw
// character, or emit next refresh byte); each item yields exactly one word
// on the m_ channel, held in an output register until m_ready takes it.
// A load or an unused command gives its result in the cycle after acceptance.
// A refresh command byte goes straight to the output register; a refresh data
// byte first passes the registered framebuffer read. A draw gives its result
// in the cycle after acceptance; with a valid symbol and line it keeps s_ready
// low while the engine forms the glyph base address, makes one font read per
// glyph byte (25) through the single font read port, and then advances the
// line column. After reset the framebuffer is cleared one entry per cycle,
// all 512 entries, with s_ready low. The next item is accepted only when the
// block is idle and the output register is empty or being taken in the same
// cycle, so a stalled receiver holds off the sender without losing any word.
module glyph_text_framebuffer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gtf_pkg::item_t    s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output gtf_pkg::result_t  m_result
);

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_DRAW,
        T_RDATA
    } top_state_t;

    top_state_t                     state_reg;
    logic [gtf_pkg::FRAME_AW-1:0]   clr_cnt_reg;
    logic [gtf_pkg::COL_W-1:0]      upper_col_reg;
    logic [gtf_pkg::COL_W-1:0]      lower_col_reg;
    logic                           draw_lower_reg;
    logic [gtf_pkg::PAGE_W-1:0]     page_reg;
    logic [gtf_pkg::OFF_W-1:0]      off_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    gtf_pkg::result_t               result_reg;
    gtf_pkg::result_t               result_next;
    logic [7:0]                     frame_rdata_reg;
    logic [7:0]                     frame_mem [gtf_pkg::FRAME_DEPTH];

    gtf_pkg::font_wr_t              font_wr;
    gtf_pkg::draw_req_t             draw_req;
    gtf_pkg::frame_wr_t             eng_frame_wr;
    gtf_pkg::draw_done_t            eng_done;
    logic                           eng_busy;

    logic                           accept;
    logic                           sym_ok;
    logic                           line_ok;
    logic [7:0]                     glyph_full;
    logic                           ref_cmd;
    logic                           ref_last;
    logic [7:0]                     ref_byte;
    logic [gtf_pkg::FRAME_AW-1:0]   ref_addr;
    logic                           mem_we;
    logic [gtf_pkg::FRAME_AW-1:0]   mem_addr;
    logic [7:0]                     mem_wdata;

    gtf_glyph_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .font_wr   (font_wr),
        .draw_req  (draw_req),
        .frame_wr  (eng_frame_wr),
        .draw_done (eng_done),
        .busy      (eng_busy)
    );

    assign s_ready  = (state_reg == T_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    always_comb begin
        sym_ok     = (s_item.symbol >= 8'(gtf_pkg::FIRST_CODE))
                     && ({1'b0, s_item.symbol}
                         < 9'(gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT));
        line_ok    = (s_item.text_line == gtf_pkg::LINE_UPPER)
                     || (s_item.text_line == gtf_pkg::LINE_LOWER);
        glyph_full = s_item.symbol - 8'(gtf_pkg::FIRST_CODE);

        draw_req.start  = accept && (s_item.command == gtf_pkg::CMD_DRAW) && sym_ok && line_ok;
        draw_req.lower  = (s_item.text_line == gtf_pkg::LINE_LOWER);
        draw_req.column = draw_req.lower ? lower_col_reg : upper_col_reg;
        draw_req.glyph  = glyph_full[gtf_pkg::GLYPH_W-1:0];

        font_wr.we   = accept && (s_item.command == gtf_pkg::CMD_LOAD)
                       && ({1'b0, s_item.font_index} < 13'(gtf_pkg::FONT_DEPTH));
        font_wr.addr = s_item.font_index[gtf_pkg::FONT_AW-1:0];
        font_wr.data = s_item.font_byte;

        ref_cmd  = (off_reg < gtf_pkg::OFF_W'(gtf_pkg::CMD_BYTES));
        ref_last = (page_reg == gtf_pkg::PAGE_W'(gtf_pkg::PAGE_COUNT - 1))
                   && (off_reg == gtf_pkg::OFF_W'(gtf_pkg::PAGE_STREAM - 1));
        ref_addr = gtf_pkg::FRAME_AW'(page_reg) * gtf_pkg::FRAME_AW'(gtf_pkg::PANEL_COLUMNS)
                   + gtf_pkg::FRAME_AW'(off_reg - gtf_pkg::OFF_W'(gtf_pkg::CMD_BYTES));
        case (off_reg)
            gtf_pkg::OFF_COL_LO: ref_byte = gtf_pkg::BYTE_COL_LO;
            gtf_pkg::OFF_COL_HI: ref_byte = gtf_pkg::BYTE_COL_HI;
            default:             ref_byte = gtf_pkg::BYTE_PAGE_BASE + 8'(page_reg);
        endcase

        result_next = '0;
        case (s_item.command)
            gtf_pkg::CMD_DRAW: begin
                result_next.bad_symbol = !sym_ok;
            end
            gtf_pkg::CMD_REFRESH: begin
                result_next.out_valid   = 1'b1;
                result_next.out_is_data = !ref_cmd;
                result_next.out_byte    = ref_cmd ? ref_byte : 8'h00;
                result_next.frame_last  = ref_last;
            end
            default: begin
                result_next = '0;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        if (accept && !((s_item.command == gtf_pkg::CMD_REFRESH) && !ref_cmd)) begin
            m_valid_next = 1'b1;
        end
        if (state_reg == T_RDATA) begin
            m_valid_next = 1'b1;
        end

        mem_we    = (state_reg == T_CLEAR) || eng_frame_wr.we;
        mem_wdata = (state_reg == T_CLEAR) ? 8'h00 : eng_frame_wr.data;
        if (state_reg == T_CLEAR) begin
            mem_addr = clr_cnt_reg;
        end else if (eng_frame_wr.we) begin
            mem_addr = eng_frame_wr.addr;
        end else begin
            mem_addr = ref_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        frame_rdata_reg <= frame_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_CLEAR;
            clr_cnt_reg   <= '0;
            upper_col_reg <= '0;
            lower_col_reg <= '0;
            page_reg      <= '0;
            off_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                T_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + gtf_pkg::FRAME_AW'(1);
                    if (clr_cnt_reg == gtf_pkg::FRAME_AW'(gtf_pkg::FRAME_DEPTH - 1)) begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (accept) begin
                        result_reg <= result_next;
                        if (s_item.command == gtf_pkg::CMD_REFRESH) begin
                            if (off_reg == gtf_pkg::OFF_W'(gtf_pkg::PAGE_STREAM - 1)) begin
                                off_reg  <= '0;
                                page_reg <= page_reg + gtf_pkg::PAGE_W'(1);
                            end else begin
                                off_reg <= off_reg + gtf_pkg::OFF_W'(1);
                            end
                        end
                        if ((s_item.command == gtf_pkg::CMD_REFRESH) && !ref_cmd) begin
                            state_reg <= T_RDATA;
                        end else if (draw_req.start) begin
                            draw_lower_reg <= draw_req.lower;
                            state_reg      <= T_DRAW;
                        end
                    end
                end
                T_DRAW: begin
                    if (eng_done.done) begin
                        if (draw_lower_reg) begin
                            lower_col_reg <= eng_done.column;
                        end else begin
                            upper_col_reg <= eng_done.column;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                T_RDATA: begin
                    result_reg.out_byte <= frame_rdata_reg;
                    state_reg           <= T_IDLE;
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_ready_engine_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !eng_busy)
        else $error("item accepted while glyph engine busy");

    a_no_draw_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_CLEAR) |-> !eng_frame_wr.we)
        else $error("glyph write during framebuffer clear");

    a_rdata_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_RDATA) |=> m_valid)
        else $error("refresh data byte not presented");

    a_column_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (upper_col_reg <= gtf_pkg::COL_W'(gtf_pkg::PANEL_COLUMNS))
        && (lower_col_reg <= gtf_pkg::COL_W'(gtf_pkg::PANEL_COLUMNS)))
        else $error("line column beyond panel width");

    a_done_in_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_done.done |-> (state_reg == T_DRAW))
        else $error("glyph engine finished outside a draw");
`endif

endmodule

// ===== sim/glyph_text_framebuffer_test.sv =====
// Self-checking testbench for glyph_text_framebuffer: font loads, glyph draws
// and the refresh stream are predicted word by word and checked.
// Depends on gtf_pkg and the glyph_text_framebuffer RTL.
module glyph_text_framebuffer_test;

    localparam int STREAM_WORDS   = gtf_pkg::PAGE_COUNT * gtf_pkg::PAGE_STREAM;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    gtf_pkg::item_t   s_item  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    gtf_pkg::result_t m_result;

    glyph_text_framebuffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [7:0] font_mem [gtf_pkg::FONT_DEPTH];
    logic [7:0] frame_mem [gtf_pkg::FRAME_DEPTH] = '{default: 8'h00};
    int         upper_col = 0;
    int         lower_col = 0;
    int         refresh_pos = 0;

    bit         font_written [gtf_pkg::FONT_DEPTH];
    int         glyph_fill [gtf_pkg::GLYPH_COUNT];
    int         ready_glyphs[$];

    gtf_pkg::result_t pending_words[$];
    int         mismatches = 0;
    int         sent_items = 0;
    int         burst_left = 0;
    int         quiet_cycles = 0;
    bit         long_hold_req = 1'b0;
    int         hold_left = 0;
    int         ready_phase = 0;
    int         ready_mode = 0;

    function automatic int place_glyph(int column, int first_page, int code);
        int base;
        int col;
        base = (code - gtf_pkg::FIRST_CODE) * gtf_pkg::GLYPH_BYTES;
        for (int k = 0; k < gtf_pkg::GLYPH_COLUMNS; k++) begin
            col = column + k;
            if (col < gtf_pkg::PANEL_COLUMNS) begin
                frame_mem[first_page * gtf_pkg::PANEL_COLUMNS + col] =
                    font_mem[base + 1 + 2 * k];
                frame_mem[(first_page + 1) * gtf_pkg::PANEL_COLUMNS + col] =
                    font_mem[base + 2 + 2 * k];
            end
        end
        column += font_mem[base];
        if (column > gtf_pkg::PANEL_COLUMNS) begin
            column = gtf_pkg::PANEL_COLUMNS;
        end
        return column;
    endfunction

    function automatic gtf_pkg::result_t next_panel_word(gtf_pkg::item_t it);
        gtf_pkg::result_t r;
        int      pos;
        int      page;
        int      off;
        r = '0;
        case (it.command)
            gtf_pkg::CMD_LOAD: begin
                if (it.font_index < gtf_pkg::FONT_DEPTH) begin
                    font_mem[it.font_index] = it.font_byte;
                end
            end
            gtf_pkg::CMD_DRAW: begin
                if (it.symbol < gtf_pkg::FIRST_CODE
                    || it.symbol >= gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT) begin
                    r.bad_symbol = 1'b1;
                end else if (it.text_line == gtf_pkg::LINE_UPPER) begin
                    upper_col = place_glyph(upper_col, 0, it.symbol);
                end else if (it.text_line == gtf_pkg::LINE_LOWER) begin
                    lower_col = place_glyph(lower_col, 2, it.symbol);
                end
            end
            gtf_pkg::CMD_REFRESH: begin
                pos = (refresh_pos >= STREAM_WORDS) ? 0 : refresh_pos;
                page = pos / gtf_pkg::PAGE_STREAM;
                off = pos % gtf_pkg::PAGE_STREAM;
                r.out_valid = 1'b1;
                if (off == 0) begin
                    r.out_byte = gtf_pkg::BYTE_COL_LO;
                end else if (off == 1) begin
                    r.out_byte = gtf_pkg::BYTE_COL_HI;
                end else if (off == 2) begin
                    r.out_byte = gtf_pkg::BYTE_PAGE_BASE + 8'(page);
                end else begin
                    r.out_is_data = 1'b1;
                    r.out_byte = frame_mem[page * gtf_pkg::PANEL_COLUMNS + off
                                           - gtf_pkg::CMD_BYTES];
                end
                pos++;
                if (pos >= STREAM_WORDS) begin
                    r.frame_last = 1'b1;
                    pos = 0;
                end
                refresh_pos = pos;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        gtf_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %h", $time, m_result);
            end else begin
                want = pending_words.pop_front();
                compare_field("out_valid", want.out_valid, m_result.out_valid);
                compare_field("out_is_data", want.out_is_data, m_result.out_is_data);
                compare_field("out_byte", want.out_byte, m_result.out_byte);
                compare_field("frame_last", want.frame_last, m_result.frame_last);
                compare_field("bad_symbol", want.bad_symbol, m_result.bad_symbol);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            ready_phase++;
            if (ready_phase % 97 == 0) begin
                ready_mode = $urandom_range(2);
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                default: m_ready <= ((ready_phase % 7) < 3);
            endcase
        end
    end

    task automatic send_word(input gtf_pkg::item_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(next_panel_word(it));
        sent_items++;
    endtask

    task automatic issue(input gtf_pkg::item_t it);
        send_word(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_font(input logic [11:0] addr, input logic [7:0] value);
        gtf_pkg::item_t it;
        int    g;
        it = gtf_pkg::item_t'($urandom);
        it.command = gtf_pkg::CMD_LOAD;
        it.font_index = addr;
        it.font_byte = value;
        issue(it);
        if (addr < gtf_pkg::FONT_DEPTH && !font_written[addr]) begin
            font_written[addr] = 1'b1;
            g = addr / gtf_pkg::GLYPH_BYTES;
            glyph_fill[g]++;
            if (glyph_fill[g] == gtf_pkg::GLYPH_BYTES) begin
                ready_glyphs.push_back(g);
            end
        end
    endtask

    task automatic load_glyph(input int g, input logic [7:0] width);
        for (int k = 0; k < gtf_pkg::GLYPH_BYTES; k++) begin
            load_font(12'(g * gtf_pkg::GLYPH_BYTES + k),
                      (k == 0) ? width : 8'($urandom_range(255)));
        end
    endtask

    task automatic draw_symbol(input logic [1:0] line, input logic [7:0] code);
        gtf_pkg::item_t it;
        it = gtf_pkg::item_t'($urandom);
        it.command = gtf_pkg::CMD_DRAW;
        it.text_line = line;
        it.symbol = code;
        issue(it);
    endtask

    task automatic refresh_step();
        gtf_pkg::item_t it;
        it = gtf_pkg::item_t'($urandom);
        it.command = gtf_pkg::CMD_REFRESH;
        issue(it);
    endtask

    function automatic logic [7:0] random_width();
        return ($urandom_range(9) == 0) ? 8'($urandom_range(12)) : 8'($urandom_range(5));
    endfunction

    function automatic logic [7:0] random_ready_code();
        return 8'(gtf_pkg::FIRST_CODE + ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
    endfunction

    task automatic test_font_load();
        load_glyph(0, 8'd3);
        load_glyph(gtf_pkg::GLYPH_COUNT - 1, 8'd12);
        load_glyph($urandom_range(1, gtf_pkg::GLYPH_COUNT - 2), random_width());
        load_font(12'd1, 8'h00);
        load_font(12'd2, 8'hFF);
        load_font(12'(gtf_pkg::FONT_DEPTH), 8'h5A);
        load_font(12'hFFF, 8'hA5);
        wait_drain();
    endtask

    task automatic test_draw_cases();
        gtf_pkg::item_t it;
        draw_symbol(gtf_pkg::LINE_UPPER, 8'(gtf_pkg::FIRST_CODE));
        draw_symbol(gtf_pkg::LINE_LOWER, 8'(gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT - 1));
        draw_symbol(2'd0, 8'(gtf_pkg::FIRST_CODE));
        draw_symbol(2'd3, 8'(gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT - 1));
        draw_symbol(gtf_pkg::LINE_UPPER, 8'(gtf_pkg::FIRST_CODE - 1));
        draw_symbol(gtf_pkg::LINE_LOWER, 8'(gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT));
        draw_symbol(2'd0, 8'h00);
        draw_symbol(2'd3, 8'hFF);
        it = gtf_pkg::item_t'($urandom);
        it.command = gtf_pkg::CMD_NONE;
        issue(it);
        repeat (4) refresh_step();
        wait_drain();
    endtask

    task automatic test_output_hold();
        gtf_pkg::item_t it;
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            it = gtf_pkg::item_t'($urandom);
            it.command = (i % 3 == 0) ? gtf_pkg::CMD_LOAD : gtf_pkg::CMD_REFRESH;
            if (it.command == gtf_pkg::CMD_LOAD) begin
                it.font_index = 12'($urandom_range(gtf_pkg::FONT_DEPTH, 4095));
            end
            send_word(it);
        end
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count);
        int          stop_at;
        int          sel;
        int          g;
        int          free_glyphs[$];
        gtf_pkg::item_t it;
        stop_at = sent_items + count;
        while (sent_items < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                refresh_step();
            end else if (sel < 57) begin
                if ($urandom_range(4) == 0) begin
                    g = $urandom_range(255);
                    if (g >= gtf_pkg::FIRST_CODE
                        && g < gtf_pkg::FIRST_CODE + gtf_pkg::GLYPH_COUNT) begin
                        g = gtf_pkg::FIRST_CODE - 1 - (g % gtf_pkg::FIRST_CODE);
                    end
                    draw_symbol(2'($urandom_range(3)), 8'(g));
                end else begin
                    draw_symbol(($urandom_range(9) == 0) ? 2'(3 * $urandom_range(1)) :
                                2'($urandom_range(1, 2)), random_ready_code());
                end
            end else if (sel < 70) begin
                g = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
                sel = $urandom_range(gtf_pkg::GLYPH_BYTES - 1);
                load_font(12'(g * gtf_pkg::GLYPH_BYTES + sel),
                          (sel == 0) ? random_width() : 8'($urandom_range(255)));
            end else if (sel < 75) begin
                free_glyphs.delete();
                for (int i = 0; i < gtf_pkg::GLYPH_COUNT; i++) begin
                    if (glyph_fill[i] != gtf_pkg::GLYPH_BYTES) begin
                        free_glyphs.push_back(i);
                    end
                end
                g = (free_glyphs.size() != 0) ?
                    free_glyphs[$urandom_range(free_glyphs.size() - 1)] :
                    $urandom_range(gtf_pkg::GLYPH_COUNT - 1);
                load_glyph(g, random_width());
            end else if (sel < 80) begin
                load_font(12'($urandom_range(gtf_pkg::FONT_DEPTH, 4095)),
                          8'($urandom_range(255)));
            end else if (sel < 86) begin
                it = gtf_pkg::item_t'($urandom);
                it.command = gtf_pkg::CMD_NONE;
                issue(it);
            end else begin
                refresh_step();
            end
        end
        wait_drain();
    endtask

    task automatic test_saturation();
        int g;
        g = ready_glyphs[0];
        load_font(12'(g * gtf_pkg::GLYPH_BYTES), 8'hFF);
        repeat (2) begin
            draw_symbol(gtf_pkg::LINE_UPPER, 8'(gtf_pkg::FIRST_CODE + g));
            draw_symbol(gtf_pkg::LINE_LOWER, 8'(gtf_pkg::FIRST_CODE + g));
        end
        draw_symbol(gtf_pkg::LINE_UPPER, random_ready_code());
        wait_drain();
    endtask

    task automatic test_full_frame();
        do begin
            refresh_step();
        end while (refresh_pos != 0);
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_font_load();
        test_draw_cases();
        test_output_hold();
        test_random_traffic(100);
        test_saturation();
        test_full_frame();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== glyph_text_framebuffer.f =====
rtl/gtf_pkg.sv
rtl/gtf_glyph_engine.sv
rtl/glyph_text_framebuffer.sv
sim/glyph_text_framebuffer_test.sv
